/* hw/rtl/gmbfs_pkg.sv */
// Shared types, constants and a helper function of the grid maze path finder.
package gmbfs_pkg;

  localparam int unsigned MaxRows    = 8;
  localparam int unsigned MaxCols    = 8;
  localparam int unsigned StoreCells = MaxRows * MaxCols;
  localparam int unsigned CellW      = $clog2(StoreCells);
  localparam int unsigned PtrW       = CellW + 1;
  localparam int unsigned DimW       = 4;

  typedef logic [CellW-1:0] cell_t;
  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [DimW-1:0]  dim_t;

  typedef enum logic [0:0] {
    KindLoad  = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    RegColumns = 1'b0,
    RegRows    = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic       kind;
    logic [5:0] load_cell;
    logic       right_wall;
    logic       bottom_wall;
    logic [5:0] start_cell;
    logic [5:0] end_cell;
  } in_word_t;

  typedef struct packed {
    logic [5:0] path_cell;
    logic       found;
    logic       last;
  } out_word_t;

  // Neighbour order follows the search: left, up, right, down.
  typedef enum logic [1:0] {
    DirLeft  = 2'd0,
    DirUp    = 2'd1,
    DirRight = 2'd2,
    DirDown  = 2'd3
  } dir_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_vis;     // clear visited marks, reset queue, enqueue start
    logic load_cur;      // pop queue head into the current cell register
    logic check_nb;      // examine neighbour in direction dir
    dir_e dir;
    logic walk_init;     // begin the walk back at the end cell
    logic walk_step;     // store current walk cell, step to predecessor
    logic emit_init;     // point the emit pointer at the first path cell
    logic emit_step;     // present one path cell
    logic emit_fail;     // present the single not-found word
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_bad;     // start or end outside the cells in use
    logic queue_empty;
    logic cur_is_end;
    logic walk_at_start;
    logic walk_full;
    logic emit_done;     // the word being read out is the last one
  } dp_stat_t;

  function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
    dim_t r;
    r = v;
    if (v == '0) r = dim_t'(1);
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

/* hw/rtl/gmbfs_ctrl.sv */
// Controller state machine that sequences load, search, walk back and emit.
module gmbfs_ctrl import gmbfs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  in_word_t in_word_i,
  output logic     busy_o,
  output logic     take_o,
  output dp_cmd_t  cmd_o,
  input  dp_stat_t stat_i
);

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StCheck = 8'b00000010,
    StPop   = 8'b00000100,
    StNb    = 8'b00001000,
    StWalk  = 8'b00010000,
    StEmit0 = 8'b00100000,
    StEmit  = 8'b01000000,
    StFail  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  dir_e   dir_q, dir_d;

  assign busy_o = (state_q != StIdle);
  assign take_o = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    dir_d   = dir_q;
    cmd_o   = '0;
    cmd_o.dir = dir_q;
    case (state_q)
      StIdle: begin
        if (take_o && in_word_i.kind == KindQuery) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.range_bad) begin
          state_d = StFail;
        end else begin
          cmd_o.clear_vis = 1'b1;
          state_d = StPop;
        end
      end
      StPop: begin
        if (stat_i.queue_empty) begin
          state_d = StFail;
        end else begin
          cmd_o.load_cur = 1'b1;
          dir_d   = DirLeft;
          state_d = StNb;
        end
      end
      StNb: begin
        if (stat_i.cur_is_end) begin
          cmd_o.walk_init = 1'b1;
          state_d = StWalk;
        end else begin
          cmd_o.check_nb = 1'b1;
          dir_d = dir_e'(dir_q + 2'd1);
          if (dir_q == DirDown) state_d = StPop;
        end
      end
      StWalk: begin
        cmd_o.walk_step = 1'b1;
        if (stat_i.walk_at_start || stat_i.walk_full) state_d = StEmit0;
      end
      StEmit0: begin
        cmd_o.emit_init = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit_step = 1'b1;
        if (stat_i.emit_done) state_d = StIdle;
      end
      StFail: begin
        cmd_o.emit_fail = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dir_q   <= DirLeft;
    end else begin
      state_q <= state_d;
      dir_q   <= dir_d;
    end
  end

endmodule

/* hw/rtl/gmbfs_dp.sv */
// Datapath: wall store, visited marks, queue, predecessor and path memories.
module gmbfs_dp import gmbfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  in_word_t  in_word_i,
  input  dim_t      cols_i,
  input  dim_t      rows_i,
  input  dp_cmd_t   cmd_i,
  output dp_stat_t  stat_o,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  logic [StoreCells-1:0] right_q, bottom_q, vis_q;
  cell_t queue_mem [StoreCells];
  cell_t pred_mem  [StoreCells];
  cell_t path_mem  [StoreCells];

  cell_t start_q, end_q, cur_q, walk_q;
  ptr_t  head_q, tail_q, len_q, eptr_q;
  logic      out_valid_q;
  out_word_t out_word_q;

  dim_t cols, rows;
  ptr_t ncells;
  assign cols   = clamp_dim(cols_i, dim_t'(MaxCols));
  assign rows   = clamp_dim(rows_i, dim_t'(MaxRows));
  assign ncells = ptr_t'(cols * rows);

  // Row and column of the current cell, found by comparing against every row start at once.
  dim_t cur_row, cur_col;
  always_comb begin
    cur_row = '0;
    for (int r = 1; r < MaxRows; r++) begin
      if (cur_q >= cell_t'(r) * cell_t'(cols)) cur_row = dim_t'(r);
    end
    cur_col = dim_t'(cur_q - cell_t'(cur_row) * cell_t'(cols));
  end

  // Neighbour examined this cycle.
  logic  nb_ok;
  cell_t nb;
  always_comb begin
    nb_ok = 1'b0;
    nb    = cur_q;
    case (cmd_i.dir)
      DirLeft: begin
        nb    = cur_q - cell_t'(1);
        nb_ok = (cur_col != '0) && !right_q[nb];
      end
      DirUp: begin
        nb    = cur_q - cell_t'(cols);
        nb_ok = (cur_row != '0) && !bottom_q[nb];
      end
      DirRight: begin
        nb    = cur_q + cell_t'(1);
        nb_ok = (cur_col != cols - dim_t'(1)) && !right_q[cur_q];
      end
      DirDown: begin
        nb    = cur_q + cell_t'(cols);
        nb_ok = (cur_row != rows - dim_t'(1)) && !bottom_q[cur_q];
      end
      default: nb_ok = 1'b0;
    endcase
  end

  logic enq;
  assign enq = cmd_i.check_nb && nb_ok && !vis_q[nb] && (tail_q < ptr_t'(StoreCells));

  assign stat_o.range_bad     = ({1'b0, start_q} >= ncells) || ({1'b0, end_q} >= ncells);
  assign stat_o.queue_empty   = (head_q >= tail_q);
  assign stat_o.cur_is_end    = (cur_q == end_q);
  assign stat_o.walk_at_start = (walk_q == start_q);
  assign stat_o.walk_full     = (len_q == ptr_t'(StoreCells - 1));
  assign stat_o.emit_done     = (eptr_q == ptr_t'(StoreCells - 1));

  // Wall store: valid resets to closed walls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q  <= '1;
      bottom_q <= '1;
    end else if (take_i && in_word_i.kind == KindLoad) begin
      right_q[in_word_i.load_cell[CellW-1:0]]  <= in_word_i.right_wall;
      bottom_q[in_word_i.load_cell[CellW-1:0]] <= in_word_i.bottom_wall;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit_step || cmd_i.emit_fail;
      if (cmd_i.clear_vis) begin
        vis_q  <= {{(StoreCells-1){1'b0}}, 1'b1} << start_q;
        head_q <= '0;
        tail_q <= ptr_t'(1);
      end else begin
        if (cmd_i.load_cur) head_q <= head_q + ptr_t'(1);
        if (enq) begin
          vis_q[nb] <= 1'b1;
          tail_q    <= tail_q + ptr_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      start_q <= in_word_i.start_cell;
      end_q   <= in_word_i.end_cell;
    end
    if (cmd_i.clear_vis) queue_mem[0] <= start_q;
    else if (enq) begin
      queue_mem[tail_q[CellW-1:0]] <= nb;
      pred_mem[nb] <= cur_q;
    end
    if (cmd_i.load_cur) begin
      cur_q <= queue_mem[head_q[CellW-1:0]];
    end
    if (cmd_i.walk_init) begin
      walk_q <= end_q;
      len_q  <= '0;
    end else if (cmd_i.walk_step) begin
      path_mem[CellW'(StoreCells - 1) - len_q[CellW-1:0]] <= walk_q;
      walk_q <= pred_mem[walk_q];
      len_q  <= len_q + ptr_t'(1);
    end
    if (cmd_i.emit_init) begin
      eptr_q <= ptr_t'(StoreCells) - len_q;
    end else if (cmd_i.emit_step) begin
      eptr_q <= eptr_q + ptr_t'(1);
    end
    if (cmd_i.emit_step) begin
      out_word_q.path_cell <= path_mem[eptr_q[CellW-1:0]];
      out_word_q.found     <= 1'b1;
      out_word_q.last      <= stat_o.emit_done;
    end else if (cmd_i.emit_fail) begin
      out_word_q.path_cell <= '0;
      out_word_q.found     <= 1'b0;
      out_word_q.last      <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

/* hw/rtl/grid_maze_bfs_path_finder.sv */
// Top level of the grid maze breadth-first path finder.
//
//   channel   direction  handshake                 payload
//   command   in         start / busy              in_word_i  (in_word_t)
//   config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   result    out        out_valid_o strobe        out_word_o (out_word_t)
//
// A load does not leave the block busy. A query checks the range, then takes cells
// from the queue and checks their neighbours, one neighbour check a cycle, until it
// takes the end cell; it then walks back along the predecessors, sets up the emit and
// presents one word per path cell, each the cycle after it is read out. An out-of-range
// query goes from the range check straight to its not-found word, as does a query whose
// queue runs empty. Reset sets every wall closed and both dimensions to eight.
// Result words are one-cycle strobes; the receiver cannot stall them.
module grid_maze_bfs_path_finder import gmbfs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word_i,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  dim_t      cfg_data_i,
  output logic      out_valid_o,
  output out_word_t out_word_o
);

  dim_t     cols_q, rows_q;
  logic     take;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= dim_t'(MaxCols);
      rows_q <= dim_t'(MaxRows);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegColumns) cols_q <= cfg_data_i;
      else rows_q <= cfg_data_i;
    end
  end

  gmbfs_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .in_word_i, .busy_o(busy),
    .take_o(take), .cmd_o(cmd), .stat_i(stat)
  );

  gmbfs_dp u_dp (
    .clk_i, .rst_ni, .take_i(take), .in_word_i,
    .cols_i(cols_q), .rows_i(rows_q), .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_word_o
  );

endmodule

/* hw/rtl/gmbfs_checker.sv */
// Port-level checker for the path finder, bound to the top level.
module gmbfs_checker import gmbfs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_i,
  input in_word_t  in_word_i,
  input logic      out_valid_i,
  input out_word_t out_word_i
);

  // A load never occupies the block beyond its own cycle.
  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_i && in_word_i.kind == KindLoad) |=> !busy_i)
    else $error("load left block busy");

  // A not-found word is always the last of its query.
  a_fail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_word_i.found) |-> out_word_i.last)
    else $error("not-found word without last");

  // Words appear only while a query is in progress.
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $past(busy_i))
    else $error("word outside query");

  // After the last word the block is free again.
  a_last_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_word_i.last) |-> !busy_i)
    else $error("busy after last word");

endmodule

bind grid_maze_bfs_path_finder gmbfs_checker u_gmbfs_checker (
  .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .in_word_i,
  .out_valid_i(out_valid_o), .out_word_i(out_word_o)
);
